### rtl/mme_pkg.sv
// Shared widths, action codes and control types for the matrix multiply engine.
package mme_pkg;

    localparam int ACTION_W = 2;
    localparam int IDX_W    = 4;
    localparam int ELEM_W   = 16;
    localparam int PROD_W   = 32;
    localparam int DOT_W    = 40;
    localparam int LEN_W    = 5;

    localparam logic [LEN_W-1:0] INNER_LEN_RESET = 5'd16;

    typedef logic [ACTION_W-1:0] t_action;

    localparam t_action ACT_WRITE_A = 2'd0;
    localparam t_action ACT_WRITE_B = 2'd1;
    localparam t_action ACT_COMPUTE = 2'd2;
    localparam t_action ACT_NONE    = 2'd3;

    typedef logic [IDX_W-1:0]         t_index;
    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [DOT_W-1:0]  t_dot;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;  // zero the accumulator for a new output element
        logic valid;  // operand pair is present this cycle
    } t_mac_ctrl;

endpackage

### rtl/mme_channels.sv
// Valid/ready channel interfaces for request items and result items.
interface mme_req_if;
    logic              valid;
    logic              ready;
    mme_pkg::t_action  action;
    mme_pkg::t_index   row_index;
    mme_pkg::t_index   col_index;
    mme_pkg::t_elem    element_value;

    modport source (output valid, output action, output row_index, output col_index,
                    output element_value, input ready);
    modport sink   (input valid, input action, input row_index, input col_index,
                    input element_value, output ready);
endinterface

interface mme_rsp_if;
    logic              valid;
    logic              ready;
    mme_pkg::t_dot     dot_product;
    mme_pkg::t_index   out_row;
    mme_pkg::t_index   out_col;

    modport source (output valid, output dot_product, output out_row, output out_col,
                    input ready);
    modport sink   (input valid, input dot_product, input out_row, input out_col,
                    output ready);
endinterface

### rtl/mme_mac.sv
// Shared multiply-accumulate unit: registered product, then 40-bit accumulate.
module mme_mac (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mme_pkg::t_mac_ctrl i_ctrl,
    input  mme_pkg::t_elem     i_a,
    input  mme_pkg::t_elem     i_b,
    output mme_pkg::t_dot      o_acc,
    output logic               o_busy
);

    logic                              r_prod_vld;
    logic signed [mme_pkg::PROD_W-1:0] r_prod;
    mme_pkg::t_dot                     r_acc;

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.valid) begin
            r_prod <= i_a * i_b;
        end
    end

    // Accumulate stage, wraps at 40 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + mme_pkg::DOT_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_prod_vld;

    // A new element never starts while a product is still pending
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |-> !r_prod_vld)
        else $error("accumulator cleared with a product in flight");

    // Clear and operand issue never share a cycle
    a_clear_no_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |-> !i_ctrl.valid)
        else $error("accumulator cleared while an operand pair issues");

    // Product stage follows the issue strobe in the next cycle
    a_prod_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.valid |=> r_prod_vld)
        else $error("product stage lost an issued operand pair");

endmodule

### rtl/matrix_multiply_engine.sv
// Top level: matrix stores, dot-product sequencer and result register.
//
//  channel   dir  handshake          payload
//  i_req     in   valid/ready        action, row_index, col_index, element_value
//  o_rsp     out  valid/ready        dot_product, out_row, out_col
//  i_cfg     in   i_cfg_wr_en        i_cfg_wr_data = inner_length
//
// Write items (A or B) are taken back to back. A compute item issues L terms,
// L = min(inner_length, MAX_DIM), or 0 if the row or column is outside the
// matrix, one multiply-accumulate per cycle through the shared unit, drains its
// pipeline and loads the result register; no other item is taken meanwhile.
// Reset (synchronous, active low) clears control state and sets inner_length to
// 16; the stores are not cleared. Items are taken while a result waits in the
// output register; a finished compute holds in its last step until the register is free.
module matrix_multiply_engine #(
    parameter int MAX_DIM = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [mme_pkg::LEN_W-1:0]    i_cfg_wr_data,
    mme_req_if.sink                      i_req,
    mme_rsp_if.source                    o_rsp
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW     = $clog2(MAX_DIM + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [mme_pkg::LEN_W-1:0] r_inner_len;
    logic [1:0]                r_state, n_state;
    logic [KW-1:0]             r_k, n_k;
    logic [KW-1:0]             r_len, n_len;
    mme_pkg::t_index           r_row, n_row;
    mme_pkg::t_index           r_col, n_col;
    logic                      r_rd_vld;
    mme_pkg::t_elem            r_rd_a, r_rd_b;
    mme_pkg::t_elem            r_mem_a [DEPTH];
    mme_pkg::t_elem            r_mem_b [DEPTH];
    logic                      r_out_vld;
    mme_pkg::t_dot             r_out_dot;
    mme_pkg::t_index           r_out_row, r_out_col;

    logic               req_acc, req_in_range, wr_a, wr_b, start;
    logic               rd_en, out_load;
    logic [ADDR_W-1:0]  wr_addr, rd_addr_a, rd_addr_b;
    logic [KW-1:0]      len_clamp;
    mme_pkg::t_mac_ctrl mac_ctrl;
    mme_pkg::t_dot      mac_acc;
    logic               mac_busy;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_len <= mme_pkg::INNER_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_inner_len <= i_cfg_wr_data;
        end
    end

    // Decode the incoming item
    assign i_req.ready  = (r_state == S_IDLE);
    assign req_acc      = i_req.valid && i_req.ready;
    assign req_in_range = (32'(i_req.row_index) < MAX_DIM) && (32'(i_req.col_index) < MAX_DIM);
    assign wr_a         = req_acc && (i_req.action == mme_pkg::ACT_WRITE_A) && req_in_range;
    assign wr_b         = req_acc && (i_req.action == mme_pkg::ACT_WRITE_B) && req_in_range;
    assign start        = req_acc && (i_req.action == mme_pkg::ACT_COMPUTE);
    assign wr_addr      = ADDR_W'(32'(i_req.row_index) * MAX_DIM + 32'(i_req.col_index));
    assign len_clamp    = (32'(r_inner_len) > MAX_DIM) ? KW'(MAX_DIM) : KW'(r_inner_len);

    // Operand addresses: A walks a row, B walks a column
    assign rd_addr_a = ADDR_W'(32'(r_row) * MAX_DIM + 32'(r_k));
    assign rd_addr_b = ADDR_W'(32'(r_k) * MAX_DIM + 32'(r_col));
    assign rd_en     = (r_state == S_RUN) && (r_k != r_len);
    assign out_load  = (r_state == S_DONE) && (!r_out_vld || o_rsp.ready);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_len   = r_len;
        n_row   = r_row;
        n_col   = r_col;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_RUN;
                    n_k     = '0;
                    n_row   = i_req.row_index;
                    n_col   = i_req.col_index;
                    n_len   = req_in_range ? len_clamp : '0;
                end
            end
            S_RUN: begin
                if (rd_en) begin
                    n_k = r_k + 1'b1;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !mac_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_len    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_len    <= n_len;
            r_rd_vld <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_col <= n_col;
    end

    // Matrix stores: one write port from the item, one registered read each
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_mem_a[wr_addr] <= i_req.element_value;
        end
        if (rd_en) begin
            r_rd_a <= r_mem_a[rd_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            r_mem_b[wr_addr] <= i_req.element_value;
        end
        if (rd_en) begin
            r_rd_b <= r_mem_b[rd_addr_b];
        end
    end

    // Multiply-accumulate
    assign mac_ctrl.clear = start;
    assign mac_ctrl.valid = r_rd_vld;

    mme_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_a     (r_rd_a),
        .i_b     (r_rd_b),
        .o_acc   (mac_acc),
        .o_busy  (mac_busy)
    );

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_dot <= mac_acc;
            r_out_row <= r_row;
            r_out_col <= r_col;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.dot_product = r_out_dot;
    assign o_rsp.out_row     = r_out_row;
    assign o_rsp.out_col     = r_out_col;

    // Issue index never passes the term count
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= r_len)
        else $error("inner index ran past the term count");

    // Reads only while an element is being worked
    a_rd_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_RUN || r_state == S_DRAIN))
        else $error("store read outside of a compute");

    // Result is taken from an empty pipeline only
    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (!r_rd_vld && !mac_busy))
        else $error("result loaded with terms still in flight");

endmodule
